// ===== design/sbb_pkg.sv =====
// Shared types and constants for the separable box blur block.
// No dependencies; every other design file refers to it by scoped names.
package sbb_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int MAX_RADIUS = 64;

  localparam int LANES      = 4;
  localparam int X_W        = $clog2(MAX_WIDTH);
  localparam int DIM_W      = $clog2(MAX_WIDTH) + 1;
  localparam int RAD_W      = 7;
  localparam int RING_ROWS  = 2 * MAX_RADIUS + 1;
  localparam int RING_W     = $clog2(RING_ROWS);
  localparam int LINE_DEPTH = RING_ROWS * MAX_WIDTH;
  localparam int LINE_AW    = RING_W + X_W;
  localparam int SUM_W      = 16;
  localparam int CNT_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int QUEUE_DEPTH = 4;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

  typedef struct packed {
    logic       mode;
    logic [7:0] in_blue;
    logic [7:0] in_green;
    logic [7:0] in_red;
    logic [7:0] in_alpha;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
    logic [7:0] out_alpha;
    logic       frame_last;
  } pix_out_t;

  // queue entry: pixel word with blue in the low byte
  typedef struct packed {
    logic        drain;
    logic [31:0] pix;
  } q_item_t;

  typedef struct packed {
    logic [RAD_W-1:0] radius;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic             restart;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FRD,
    ST_FACC,
    ST_HDST,
    ST_HDIV,
    ST_HWR,
    ST_URD,
    ST_UACC,
    ST_CHK,
    ST_VRD,
    ST_VACC,
    ST_VDST,
    ST_VDIV,
    ST_EMIT
  } eng_state_t;

endpackage

// ===== design/separable_box_blur_rgba.sv =====
// Top level of the separable box blur: configuration registers, input
// queue, blur engine. Depends on sbb_pkg, sbb_queue, sbb_engine.
//
//   channel  | handshake              | payload
//   ---------+------------------------+----------------------------
//   input    | in_valid / in_stall    | in_data   (sbb_pkg::pix_in_t)
//   output   | out_valid / out_stall  | out_data  (sbb_pkg::pix_out_t)
//   config   | cfg_we                 | cfg_index, cfg_data
//
// A transaction that ends a row also runs the horizontal pass (shared
// divider, single read port of the row store); an emitted pixel also runs
// the vertical pass on the line ring's read port and the divider.
// Reset is synchronous and clears the position and queue counters; stores are not cleared.
// Output stall holds the result register and the engine; input queues
// four transactions before in_stall rises.
module separable_box_blur_rgba (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  sbb_pkg::pix_in_t                 in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output sbb_pkg::pix_out_t                out_data,
  input  logic                             cfg_we,
  input  logic [sbb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sbb_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int DIM_W = sbb_pkg::DIM_W;
  localparam int RAD_W = sbb_pkg::RAD_W;

  sbb_pkg::cfg_t    cfg;
  logic             q_valid;
  sbb_pkg::q_item_t q_data;
  logic             pop;
  logic [RAD_W-1:0] rad_in;
  logic [DIM_W-1:0] dim_in;
  logic [DIM_W-1:0] dim_eff;
  logic [DIM_W-1:0] hgt_eff;
  logic             cfg_hit;

  assign rad_in  = cfg_data[RAD_W-1:0];
  assign dim_in  = cfg_data[DIM_W-1:0];
  assign dim_eff = (dim_in == '0) ? DIM_W'(1)
                 : (dim_in > DIM_W'(sbb_pkg::MAX_WIDTH)) ? DIM_W'(sbb_pkg::MAX_WIDTH)
                 : dim_in;
  assign hgt_eff = (dim_in == '0) ? DIM_W'(1)
                 : (dim_in > DIM_W'(sbb_pkg::MAX_HEIGHT)) ? DIM_W'(sbb_pkg::MAX_HEIGHT)
                 : dim_in;
  assign cfg_hit = cfg_we && ((cfg_index == sbb_pkg::REG_RADIUS) ||
                              (cfg_index == sbb_pkg::REG_WIDTH)  ||
                              (cfg_index == sbb_pkg::REG_HEIGHT));

  // configuration registers, stored already saturated
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.radius  <= '0;
      cfg.width   <= DIM_W'(1);
      cfg.height  <= DIM_W'(1);
      cfg.restart <= 1'b0;
    end else begin
      cfg.restart <= cfg_hit;
      if (cfg_we) begin
        unique case (cfg_index)
          sbb_pkg::REG_RADIUS: begin
            cfg.radius <= (rad_in > RAD_W'(sbb_pkg::MAX_RADIUS))
                          ? RAD_W'(sbb_pkg::MAX_RADIUS) : rad_in;
          end
          sbb_pkg::REG_WIDTH:  cfg.width  <= dim_eff;
          sbb_pkg::REG_HEIGHT: cfg.height <= hgt_eff;
          default: ;
        endcase
      end
    end
  end

  sbb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_data   (q_data)
  );

  sbb_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== design/sbb_queue.sv =====
// Front end: takes input transactions, tags drain ticks, and queues them.
// Depends on sbb_pkg.
module sbb_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  sbb_pkg::pix_in_t in_data,
  input  logic             pop,
  output logic             q_valid,
  output sbb_pkg::q_item_t q_data
);

  localparam int PTR_W = $clog2(sbb_pkg::QUEUE_DEPTH);

  sbb_pkg::q_item_t       slots [sbb_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]       wr_ptr;
  logic [PTR_W-1:0]       rd_ptr;
  logic [PTR_W:0]         count;
  logic                   push;
  logic                   take;
  sbb_pkg::q_item_t       item;

  // classify: drain tick or pixel, pack channels blue-first
  always_comb begin
    item.drain = in_data.mode;
    item.pix   = {in_data.in_alpha, in_data.in_red, in_data.in_green, in_data.in_blue};
  end

  assign in_stall = (count == (PTR_W+1)'(sbb_pkg::QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != '0);
  assign take     = pop && q_valid;
  assign q_data   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (take) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (PTR_W+1)'(push) - (PTR_W+1)'(take);
    end
  end

endmodule

// ===== design/sbb_div.sv =====
// Four-lane restoring divider, one quotient bit per cycle.
// Depends on sbb_pkg.
module sbb_div (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          start,
  input  logic [sbb_pkg::LANES-1:0][sbb_pkg::SUM_W-1:0] dividend,
  input  logic [sbb_pkg::CNT_W-1:0]                     divisor,
  output logic                                          done,
  output logic [sbb_pkg::LANES-1:0][7:0]                quotient
);

  localparam int STEP_W = $clog2(sbb_pkg::SUM_W);

  logic [sbb_pkg::LANES-1:0][sbb_pkg::CNT_W-1:0] rem;
  logic [sbb_pkg::LANES-1:0][sbb_pkg::CNT_W-1:0] rem_next;
  logic [sbb_pkg::LANES-1:0][sbb_pkg::SUM_W-1:0] dq;
  logic [sbb_pkg::LANES-1:0][sbb_pkg::SUM_W-1:0] dq_next;
  logic [sbb_pkg::CNT_W-1:0]                     dvs;
  logic [STEP_W-1:0]                             step;
  logic                                          busy;

  // one shift-subtract step per lane
  always_comb begin
    logic [sbb_pkg::CNT_W:0] sh;
    for (int i = 0; i < sbb_pkg::LANES; i++) begin
      sh = {rem[i], dq[i][sbb_pkg::SUM_W-1]};
      if (sh >= {1'b0, dvs}) begin
        rem_next[i] = sbb_pkg::CNT_W'(sh - {1'b0, dvs});
        dq_next[i]  = {dq[i][sbb_pkg::SUM_W-2:0], 1'b1};
      end else begin
        rem_next[i] = sbb_pkg::CNT_W'(sh);
        dq_next[i]  = {dq[i][sbb_pkg::SUM_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq  <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      dq  <= dq_next;
      rem <= rem_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      step <= '0;
    end else if (busy) begin
      step <= step + 1'b1;
      if (step == '1) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < sbb_pkg::LANES; i++) begin
      quotient[i] = dq[i][7:0];
    end
  end

endmodule

// ===== design/sbb_engine.sv =====
// Back end: source row store, horizontal pass into the line ring,
// vertical window sums, output register. Depends on sbb_pkg and sbb_div.
module sbb_engine (
  input  logic              clk,
  input  logic              rst,
  input  sbb_pkg::cfg_t     cfg,
  input  logic              q_valid,
  input  sbb_pkg::q_item_t  q_data,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output sbb_pkg::pix_out_t out_data
);

  localparam int X_W   = sbb_pkg::X_W;
  localparam int DIM_W = sbb_pkg::DIM_W;
  localparam int RW    = sbb_pkg::RING_W;
  localparam logic [RW-1:0] RING_LAST = RW'(sbb_pkg::RING_ROWS - 1);

  sbb_pkg::eng_state_t state;
  sbb_pkg::eng_state_t state_next;

  // memories
  logic [31:0] src_mem  [sbb_pkg::MAX_WIDTH];
  logic [31:0] line_mem [sbb_pkg::LINE_DEPTH];
  logic [31:0] src_rdata;
  logic [31:0] line_rdata;
  logic                      src_we;
  logic [X_W-1:0]            src_raddr;
  logic                      line_we;
  logic [sbb_pkg::LINE_AW-1:0] line_waddr;
  logic [sbb_pkg::LINE_AW-1:0] line_raddr;

  // positions
  logic [X_W-1:0]   in_col;
  logic [DIM_W-1:0] in_row;
  logic [RW-1:0]    ring_in;
  logic [X_W-1:0]   ox;
  logic [X_W-1:0]   oy;
  logic [RW-1:0]    out_ring;

  // pass control
  logic [X_W-1:0]   hx;
  logic [DIM_W-1:0] hk;
  logic             hsub;
  logic [X_W-1:0]   vrow;
  logic [X_W-1:0]   vneed;
  logic [RW-1:0]    vring;
  logic [sbb_pkg::LANES-1:0][sbb_pkg::SUM_W-1:0] acc;
  logic [sbb_pkg::CNT_W-1:0] cnt;

  // divider
  logic                                div_start;
  logic                                div_done;
  logic [sbb_pkg::LANES-1:0][7:0]      quo;

  // derived control terms
  logic [DIM_W-1:0] w_last;
  logic [DIM_W-1:0] h_last;
  logic [DIM_W-1:0] kmax;
  logic             absorb;
  logic             row_done;
  logic             rem_needed;
  logic             add_needed;
  logic [DIM_W:0]   add_k;
  logic [DIM_W-1:0] need;
  logic [DIM_W-1:0] oy_plus_r;
  logic [X_W-1:0]   top;
  logic [RW-1:0]    back;
  logic [RW-1:0]    top_ring;
  logic             out_ready;
  logic             out_free;
  logic             last_pix;

  assign w_last     = cfg.width - 1'b1;
  assign h_last     = cfg.height - 1'b1;
  assign kmax       = (DIM_W'(cfg.radius) < w_last) ? DIM_W'(cfg.radius) : w_last;
  assign absorb     = !q_data.drain && (in_row < cfg.height);
  assign row_done   = (DIM_W'(in_col) == w_last);
  assign rem_needed = (DIM_W'(hx) >= DIM_W'(cfg.radius));
  assign add_k      = (DIM_W+1)'(hx) + (DIM_W+1)'(cfg.radius) + 1'b1;
  assign add_needed = (add_k < (DIM_W+1)'(cfg.width));
  assign oy_plus_r  = DIM_W'(oy) + DIM_W'(cfg.radius);
  assign need       = (oy_plus_r < h_last) ? oy_plus_r : h_last;
  assign out_ready  = (in_row > need);
  assign top        = (DIM_W'(oy) > DIM_W'(cfg.radius)) ? X_W'(oy - X_W'(cfg.radius)) : '0;
  assign back       = RW'(oy - top);
  assign top_ring   = (out_ring >= back) ? (out_ring - back)
                                         : RW'(out_ring + RW'(sbb_pkg::RING_ROWS) - back);
  assign out_free   = !out_valid || !out_stall;
  assign last_pix   = (DIM_W'(ox) == w_last) && (DIM_W'(oy) == h_last);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      sbb_pkg::ST_IDLE: begin
        if (q_valid) begin
          state_next = (absorb && row_done) ? sbb_pkg::ST_FRD : sbb_pkg::ST_CHK;
        end
      end
      sbb_pkg::ST_FRD:  state_next = sbb_pkg::ST_FACC;
      sbb_pkg::ST_FACC: state_next = (hk == kmax) ? sbb_pkg::ST_HDST : sbb_pkg::ST_FRD;
      sbb_pkg::ST_HDST: state_next = sbb_pkg::ST_HDIV;
      sbb_pkg::ST_HDIV: if (div_done) state_next = sbb_pkg::ST_HWR;
      sbb_pkg::ST_HWR: begin
        priority if (DIM_W'(hx) == w_last) state_next = sbb_pkg::ST_CHK;
        else if (rem_needed || add_needed) state_next = sbb_pkg::ST_URD;
        else                               state_next = sbb_pkg::ST_HDST;
      end
      sbb_pkg::ST_URD:  state_next = sbb_pkg::ST_UACC;
      sbb_pkg::ST_UACC: state_next = (hsub && add_needed) ? sbb_pkg::ST_URD
                                                          : sbb_pkg::ST_HDST;
      sbb_pkg::ST_CHK:  state_next = out_ready ? sbb_pkg::ST_VRD : sbb_pkg::ST_IDLE;
      sbb_pkg::ST_VRD:  state_next = sbb_pkg::ST_VACC;
      sbb_pkg::ST_VACC: state_next = (vrow == vneed) ? sbb_pkg::ST_VDST : sbb_pkg::ST_VRD;
      sbb_pkg::ST_VDST: state_next = sbb_pkg::ST_VDIV;
      sbb_pkg::ST_VDIV: if (div_done) state_next = sbb_pkg::ST_EMIT;
      sbb_pkg::ST_EMIT: if (out_free) state_next = sbb_pkg::ST_IDLE;
      default:          state_next = sbb_pkg::ST_IDLE;
    endcase
  end

  // memory and divider controls
  always_comb begin
    pop        = (state == sbb_pkg::ST_IDLE) && q_valid;
    src_we     = pop && absorb;
    src_raddr  = hk[X_W-1:0];
    line_we    = (state == sbb_pkg::ST_HWR);
    line_waddr = {ring_in, hx};
    line_raddr = {vring, ox};
    div_start  = (state == sbb_pkg::ST_HDST) || (state == sbb_pkg::ST_VDST);
  end

  always_ff @(posedge clk) begin
    if (src_we) src_mem[in_col] <= q_data.pix;
    src_rdata <= src_mem[src_raddr];
  end

  always_ff @(posedge clk) begin
    if (line_we) line_mem[line_waddr] <= quo;
    line_rdata <= line_mem[line_raddr];
  end

  sbb_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (acc),
    .divisor  (cnt),
    .done     (div_done),
    .quotient (quo)
  );

  // result valid: set on emit, cleared when the transaction is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == sbb_pkg::ST_EMIT) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sbb_pkg::ST_IDLE;
      in_col    <= '0;
      in_row    <= '0;
      ring_in   <= '0;
      ox        <= '0;
      oy        <= '0;
      out_ring  <= '0;
    end else begin
      state <= state_next;
      if (cfg.restart) begin
        in_col   <= '0;
        in_row   <= '0;
        ring_in  <= '0;
        ox       <= '0;
        oy       <= '0;
        out_ring <= '0;
      end else begin
        unique case (state)
          sbb_pkg::ST_IDLE: begin
            if (pop && absorb) begin
              in_col <= row_done ? '0 : in_col + 1'b1;
            end
          end
          sbb_pkg::ST_HWR: begin
            if (DIM_W'(hx) == w_last) begin
              in_row  <= in_row + 1'b1;
              ring_in <= (ring_in == RING_LAST) ? '0 : ring_in + 1'b1;
            end
          end
          sbb_pkg::ST_EMIT: begin
            if (out_free) begin
              priority if (last_pix) begin
                in_col   <= '0;
                in_row   <= '0;
                ring_in  <= '0;
                ox       <= '0;
                oy       <= '0;
                out_ring <= '0;
              end else if (DIM_W'(ox) == w_last) begin
                ox       <= '0;
                oy       <= oy + 1'b1;
                out_ring <= (out_ring == RING_LAST) ? '0 : out_ring + 1'b1;
              end else begin
                ox <= ox + 1'b1;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      sbb_pkg::ST_IDLE: begin
        acc <= '0;
        cnt <= '0;
        hk  <= '0;
        hx  <= '0;
      end
      sbb_pkg::ST_FACC: begin
        for (int i = 0; i < sbb_pkg::LANES; i++) begin
          acc[i] <= acc[i] + sbb_pkg::SUM_W'(src_rdata[8*i +: 8]);
        end
        cnt <= cnt + 1'b1;
        if (hk != kmax) hk <= hk + 1'b1;
      end
      sbb_pkg::ST_HWR: begin
        if (rem_needed) begin
          hk   <= DIM_W'(hx) - DIM_W'(cfg.radius);
          hsub <= 1'b1;
        end else if (add_needed) begin
          hk   <= DIM_W'(add_k);
          hsub <= 1'b0;
        end else begin
          hx <= hx + 1'b1;
        end
      end
      sbb_pkg::ST_UACC: begin
        for (int i = 0; i < sbb_pkg::LANES; i++) begin
          if (hsub) acc[i] <= acc[i] - sbb_pkg::SUM_W'(src_rdata[8*i +: 8]);
          else      acc[i] <= acc[i] + sbb_pkg::SUM_W'(src_rdata[8*i +: 8]);
        end
        if (hsub) cnt <= cnt - 1'b1;
        else      cnt <= cnt + 1'b1;
        if (hsub && add_needed) begin
          hk   <= DIM_W'(add_k);
          hsub <= 1'b0;
        end else begin
          hx <= hx + 1'b1;
        end
      end
      sbb_pkg::ST_CHK: begin
        acc   <= '0;
        cnt   <= '0;
        vrow  <= top;
        vneed <= X_W'(need);
        vring <= top_ring;
      end
      sbb_pkg::ST_VACC: begin
        for (int i = 0; i < sbb_pkg::LANES; i++) begin
          acc[i] <= acc[i] + sbb_pkg::SUM_W'(line_rdata[8*i +: 8]);
        end
        cnt <= cnt + 1'b1;
        if (vrow != vneed) begin
          vrow  <= vrow + 1'b1;
          vring <= (vring == RING_LAST) ? '0 : vring + 1'b1;
        end
      end
      sbb_pkg::ST_EMIT: begin
        if (out_free) begin
          out_data.out_blue   <= quo[0];
          out_data.out_green  <= quo[1];
          out_data.out_red    <= quo[2];
          out_data.out_alpha  <= quo[3];
          out_data.frame_last <= last_pix;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== design/sbb_checker.sv =====
// Port-level checks for the separable box blur top level, and its bind.
// Depends on sbb_pkg and separable_box_blur_rgba.
module sbb_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_stall,
  input  logic              out_valid,
  input  logic              out_stall,
  input  sbb_pkg::pix_out_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output transaction changed while stalled");

  // reset empties the result register
  a_rst_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // reset empties the input queue
  a_rst_in: assert property (@(posedge clk) rst |=> !in_stall)
    else $error("input stalled right after reset");

endmodule

bind separable_box_blur_rgba sbb_checker u_sbb_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== tb/sv/tb_separable_box_blur_rgba.sv =====
// Self-checking testbench for separable_box_blur_rgba: directed and random frames
// checked against a behavioral blur predictor. Depends on sbb_pkg and the design top.
`timescale 1ns / 100ps

module tb_separable_box_blur_rgba;

  localparam int IDLE_LIMIT = 100000;
  localparam int HOLD_CYCLES = 1200;
  localparam int RANDOM_ITEMS = 470;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  sbb_pkg::pix_in_t               in_data = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b1;
  sbb_pkg::pix_out_t              out_data;
  logic                           cfg_we = 1'b0;
  logic [sbb_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [sbb_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  separable_box_blur_rgba dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // clock
  initial begin
    forever #6 clk = ~clk;
  end

  // predictor state: registers, receive/output position, line stores
  int unsigned blur_r = 0, frame_w = 1, frame_h = 1;
  int unsigned rx_col = 0, rx_row = 0, tx_idx = 0;
  logic [31:0] row_pixels [sbb_pkg::MAX_WIDTH];
  logic [31:0] hblur_ring [sbb_pkg::LINE_DEPTH];

  sbb_pkg::pix_out_t blurred_q[$];
  int       mismatches = 0;
  int       pix_sent = 0, pix_got = 0, frames_done = 0;
  bit       frame_closed = 0;
  bit       quiet_in = 0, quiet_out = 0, hold_req = 0;
  int       idle_cycles = 0;

  function automatic int unsigned eff_w();
    return (frame_w == 0) ? 1
         : (frame_w > sbb_pkg::MAX_WIDTH ? sbb_pkg::MAX_WIDTH : frame_w);
  endfunction

  function automatic int unsigned eff_h();
    return (frame_h == 0) ? 1
         : (frame_h > sbb_pkg::MAX_HEIGHT ? sbb_pkg::MAX_HEIGHT : frame_h);
  endfunction

  // one transaction into the blur model; returns 1 when a pixel comes out
  function automatic bit blur_step(input sbb_pkg::pix_in_t d, output sbb_pkg::pix_out_t o);
    int unsigned w, h, y, x, need, top, cnt, lo, hi, base;
    int unsigned acc[4];
    logic [31:0] p;
    w = eff_w();
    h = eff_h();
    o = '0;
    if (!d.mode && rx_row < h && rx_col < w) begin
      row_pixels[rx_col] = {d.in_alpha, d.in_red, d.in_green, d.in_blue};
      rx_col++;
      if (rx_col >= w) begin
        // horizontal pass over the finished row
        base = (rx_row % sbb_pkg::RING_ROWS) * sbb_pkg::MAX_WIDTH;
        for (int unsigned xi = 0; xi < w; xi++) begin
          lo = (xi > blur_r) ? xi - blur_r : 0;
          hi = (xi + blur_r < w - 1) ? xi + blur_r : w - 1;
          acc = '{0, 0, 0, 0};
          for (int unsigned k = lo; k <= hi; k++)
            for (int c = 0; c < 4; c++) acc[c] += 32'(row_pixels[k][8*c +: 8]);
          for (int c = 0; c < 4; c++) p[8*c +: 8] = 8'(acc[c] / (hi - lo + 1));
          hblur_ring[base + xi] = p;
        end
        rx_col = 0;
        rx_row++;
      end
    end
    y = tx_idx / w;
    x = tx_idx % w;
    if (y >= h) begin
      rx_col = 0; rx_row = 0; tx_idx = 0;
      return 0;
    end
    need = (y + blur_r < h - 1) ? y + blur_r : h - 1;
    if (rx_row <= need) return 0;
    // vertical pass over the buffered horizontal results
    top = (y > blur_r) ? y - blur_r : 0;
    cnt = need - top + 1;
    acc = '{0, 0, 0, 0};
    for (int unsigned r = top; r <= need; r++) begin
      p = hblur_ring[(r % sbb_pkg::RING_ROWS) * sbb_pkg::MAX_WIDTH + x];
      for (int c = 0; c < 4; c++) acc[c] += 32'(p[8*c +: 8]);
    end
    o.out_blue  = 8'(acc[0] / cnt);
    o.out_green = 8'(acc[1] / cnt);
    o.out_red   = 8'(acc[2] / cnt);
    o.out_alpha = 8'(acc[3] / cnt);
    tx_idx++;
    if (tx_idx >= w * h) begin
      o.frame_last = 1'b1;
      rx_col = 0; rx_row = 0; tx_idx = 0;
    end
    return 1;
  endfunction

  task automatic report(input string what, input int got, input int want);
    $display("mismatch: %s got %0d expected %0d (result %0d)", what, got, want, pix_got);
    mismatches++;
  endtask

  // check every accepted result against the oldest expected pixel
  always @(posedge clk) begin
    sbb_pkg::pix_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (blurred_q.size() == 0) begin
        report("unexpected result", 1, 0);
      end else begin
        want = blurred_q.pop_front();
        if (out_data.out_blue != want.out_blue) report("blue", out_data.out_blue, want.out_blue);
        if (out_data.out_green != want.out_green)
          report("green", out_data.out_green, want.out_green);
        if (out_data.out_red != want.out_red) report("red", out_data.out_red, want.out_red);
        if (out_data.out_alpha != want.out_alpha)
          report("alpha", out_data.out_alpha, want.out_alpha);
        if (out_data.frame_last != want.frame_last)
          report("frame_last", out_data.frame_last, want.frame_last);
      end
      pix_got++;
    end
  end

  // watchdog on cycles with no transaction of any kind
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || rst) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: random stall per result, or one long hold-off on request
  initial begin
    int g;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 0;
      end
      g = quiet_out ? 0 : $urandom_range(0, 15);
      if (g > 0) begin
        out_stall <= 1'b1;
        repeat (g) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid && !hold_req) @(posedge clk);
    end
  end

  // send one transaction after a random gap and predict its result
  task automatic send_pix(input sbb_pkg::pix_in_t d);
    int g;
    sbb_pkg::pix_out_t o;
    g = quiet_in ? 0 : $urandom_range(0, 15);
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pix_sent++;
    if (blur_step(d, o)) begin
      blurred_q.push_back(o);
      if (o.frame_last) begin
        frames_done++;
        frame_closed = 1;
      end
    end
  endtask

  function automatic sbb_pkg::pix_in_t rand_pix(input bit drain);
    sbb_pkg::pix_in_t d;
    d = $urandom;
    d.mode = drain;
    return d;
  endfunction

  // wait until every expected pixel is out and the engine has settled
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (blurred_q.size() != 0) @(posedge clk);
    repeat (30 * eff_w() + 8 * blur_r + 200) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [sbb_pkg::CFG_IDX_W-1:0] idx, input int unsigned val);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[sbb_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      sbb_pkg::REG_RADIUS:
        blur_r = (val[6:0] > sbb_pkg::MAX_RADIUS) ? sbb_pkg::MAX_RADIUS : 32'(val[6:0]);
      sbb_pkg::REG_WIDTH:  frame_w = 32'(val[sbb_pkg::CFG_DATA_W-1:0]);
      sbb_pkg::REG_HEIGHT: frame_h = 32'(val[sbb_pkg::CFG_DATA_W-1:0]);
      default: return;
    endcase
    rx_col = 0; rx_row = 0; tx_idx = 0;
  endtask

  task automatic set_frame(input int unsigned r, input int unsigned w, input int unsigned h);
    cfg_write(sbb_pkg::REG_RADIUS, r);
    cfg_write(sbb_pkg::REG_WIDTH, w);
    cfg_write(sbb_pkg::REG_HEIGHT, h);
  endtask

  // feed pixels and drains until the frame's last pixel is predicted
  task automatic run_frame(input int drain_pct);
    int unsigned left;
    left = eff_w() * eff_h();
    frame_closed = 0;
    while (!frame_closed) begin
      if (left > 0 && $urandom_range(0, 99) >= drain_pct) begin
        send_pix(rand_pix(0));
        left--;
      end else begin
        send_pix(rand_pix(left == 0 ? 1'($urandom_range(0, 1)) : 1'b1));
      end
    end
  endtask

  // 1x1 frame at radius 0: every pixel passes through, drains give nothing
  task automatic test_passthrough();
    send_pix('{mode: 0, in_blue: 8'h00, in_green: 8'h00, in_red: 8'h00, in_alpha: 8'h00});
    send_pix('{mode: 0, in_blue: 8'hff, in_green: 8'hff, in_red: 8'hff, in_alpha: 8'hff});
    send_pix('{mode: 0, in_blue: 8'h55, in_green: 8'haa, in_red: 8'h0f, in_alpha: 8'hf0});
    send_pix('{mode: 1, in_blue: 8'hff, in_green: 8'hff, in_red: 8'hff, in_alpha: 8'hff});
    send_pix(rand_pix(0));
  endtask

  // register extremes: saturation, zero sizes, unknown index, abandoned frames
  task automatic test_register_edges();
    set_frame(100, 0, 0);
    send_pix(rand_pix(0));
    set_frame(127, 1024, 1024);
    repeat (3) send_pix(rand_pix(0));
    set_frame(0, 1024, 1);
    repeat (3) send_pix(rand_pix(0));
    set_frame(0, 1, 1024);
    repeat (4) send_pix(rand_pix(0));
    cfg_write(3, 5);
    send_pix(rand_pix(0));
    set_frame(64, 3, 2);
    run_frame(0);
  endtask

  // whole frame held back by the window, then surplus pixels act as drains
  task automatic test_overrun();
    set_frame(2, 3, 3);
    frame_closed = 0;
    repeat (9) send_pix(rand_pix(0));
    while (!frame_closed) send_pix(rand_pix(0));
  endtask

  // long receiver hold-off while the sender streams with no gaps
  task automatic test_backpressure();
    set_frame(1, 4, 6);
    quiet_in = 1;
    hold_req = 1;
    run_frame(0);
    quiet_in = 0;
    wait_idle();
  endtask

  task automatic test_random_frames();
    int start;
    start = pix_sent;
    while (pix_sent - start < RANDOM_ITEMS) begin
      quiet_in = ($urandom_range(0, 4) == 0);
      quiet_out = ($urandom_range(0, 4) == 0);
      set_frame(($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 5),
                $urandom_range(1, 8), $urandom_range(1, 6));
      if ($urandom_range(0, 9) == 0) begin
        // abandoned part-way through
        repeat ($urandom_range(1, 10)) send_pix(rand_pix($urandom_range(0, 3) == 0));
      end else begin
        run_frame($urandom_range(0, 30));
      end
    end
    quiet_in = 0;
    quiet_out = 0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_passthrough();
    test_register_edges();
    test_overrun();
    test_backpressure();
    test_random_frames();
    wait_idle();
    if (blurred_q.size() != 0) report("pixels still expected", 0, blurred_q.size());
    $display("covered %0d input transactions, %0d blurred pixels, %0d complete frames",
             pix_sent, pix_got, frames_done);
    $display("including register saturation, edge clipping, drains and a long output stall");
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
